>>> rtl/bank_switch_scanline_irq_mapper_defines.svh
// ----------------------------------------------------------------------------
// bank switch mapper assertion macros
// shared property wrappers, compiled out when NO_ASSERTIONS is set
// ----------------------------------------------------------------------------
`ifndef BANK_SWITCH_SCANLINE_IRQ_MAPPER_DEFINES_SVH
`define BANK_SWITCH_SCANLINE_IRQ_MAPPER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, quiet during reset
`define BSIM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bsim assertion failed");

// next-cycle implication, quiet during reset
`define BSIM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bsim assertion failed");

`else

`define BSIM_ASSERT_NOW(label, ante, cons)
`define BSIM_ASSERT_NEXT(label, ante, cons)

`endif

`endif

>>> rtl/bsim_pkg.sv
// ----------------------------------------------------------------------------
// bsim_pkg
// widths, register decode codes, reset table and shared types of the mapper
// ----------------------------------------------------------------------------
`default_nettype none

package bsim_pkg;

  localparam int BANK_REG_COUNT = 8;
  localparam int BANK_IDX_W     = $clog2(BANK_REG_COUNT);

  localparam int CFG_DATA_W  = 6;
  localparam int CFG_INDEX_W = 2;

  localparam int DIVIDEND_W   = 8;
  localparam int DIVISOR_W    = 9;
  localparam int STEP_COUNT_W = $clog2(DIVIDEND_W);

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_PRG_BANKS   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_CHR_BANKS   = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_FOUR_SCREEN = 2'd2;

  // item functions
  localparam logic [1:0] FUNC_WRITE = 2'd0;
  localparam logic [1:0] FUNC_TICK  = 2'd1;
  localparam logic [1:0] FUNC_PRG   = 2'd2;
  localparam logic [1:0] FUNC_CHR   = 2'd3;

  // register decode
  localparam logic [15:0] REG_MASK        = 16'hE001;
  localparam logic [15:0] REG_BANK_SELECT = 16'h8000;
  localparam logic [15:0] REG_BANK_DATA   = 16'h8001;
  localparam logic [15:0] REG_MIRROR      = 16'hA000;
  localparam logic [15:0] REG_RAM_PROTECT = 16'hA001;
  localparam logic [15:0] REG_IRQ_LATCH   = 16'hC000;
  localparam logic [15:0] REG_IRQ_RELOAD  = 16'hC001;
  localparam logic [15:0] REG_IRQ_DISABLE = 16'hE000;
  localparam logic [15:0] REG_IRQ_ENABLE  = 16'hE001;

  localparam logic [7:0] PAIR_MASK = 8'hFE;
  localparam int SEL_PRG_SWAP_BIT = 6;
  localparam int SEL_CHR_SWAP_BIT = 7;

  // mirroring codes
  localparam logic [1:0] MIRROR_VERTICAL    = 2'd0;
  localparam logic [1:0] MIRROR_FOUR_SCREEN = 2'd2;

  localparam logic [7:0] BANK_REG_INIT [BANK_REG_COUNT] =
    '{8'd0, 8'd2, 8'd4, 8'd5, 8'd6, 8'd7, 8'd0, 8'd1};

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_EMIT
  } state_t;

  // where the translated bank comes from
  typedef enum logic [1:0] {
    SEL_REM,
    SEL_SECOND_LAST,
    SEL_LAST,
    SEL_ZERO
  } bank_sel_t;

  typedef struct packed {
    logic                  start;
    logic [DIVIDEND_W-1:0] dividend;
    logic [DIVISOR_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DIVISOR_W-1:0] remainder;
  } div_resp_t;

endpackage

`default_nettype wire

>>> rtl/bsim_if.sv
// ----------------------------------------------------------------------------
// bsim channel interfaces
// valid/ready channels for mapper items and mapper results
// ----------------------------------------------------------------------------
`default_nettype none

interface bsim_item_if import bsim_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [15:0] address;
  logic [7:0]  value;
  logic        rendering_on;

  modport source (output valid, func, address, value, rendering_on, input ready);
  modport sink   (input valid, func, address, value, rendering_on, output ready);
endinterface

interface bsim_result_if import bsim_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] bank;
  logic       irq;
  logic [1:0] mirroring;
  logic       ram_enable;
  logic       ram_writable;

  modport source (output valid, bank, irq, mirroring, ram_enable, ram_writable,
                  input ready);
  modport sink   (input valid, bank, irq, mirroring, ram_enable, ram_writable,
                  output ready);
endinterface

`default_nettype wire

>>> rtl/bsim_divider.sv
// ----------------------------------------------------------------------------
// bsim_divider
// restoring remainder unit, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module bsim_divider import bsim_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire div_req_t  req,
  output div_resp_t      resp
);

  logic                    busy;
  logic                    done;
  logic [STEP_COUNT_W-1:0] step;
  logic [DIVIDEND_W-1:0]   dq;
  logic [DIVISOR_W-1:0]    divisor;
  logic [DIVISOR_W-1:0]    rem;

  logic [DIVISOR_W:0] trial;
  logic [DIVISOR_W:0] diff;
  logic               fits;

  assign trial = {rem, dq[DIVIDEND_W-1]};
  assign diff  = trial - {1'b0, divisor};
  assign fits  = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == STEP_COUNT_W'(DIVIDEND_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dq      <= req.dividend;
      divisor <= req.divisor;
      rem     <= '0;
    end else if (busy) begin
      dq  <= {dq[DIVIDEND_W-2:0], 1'b0};
      rem <= fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
    end
  end

  assign resp.done      = done;
  assign resp.remainder = rem;

endmodule

`default_nettype wire

>>> rtl/bank_switch_scanline_irq_mapper.sv
// ----------------------------------------------------------------------------
// bank_switch_scanline_irq_mapper
// cartridge bank mapper with scanline interrupt counter
// ----------------------------------------------------------------------------
// Each transaction on the item channel is a register write, a scanline tick,
// a program address translation or a pattern address translation, and each
// produces exactly one result transaction carrying the translated bank (zero
// for writes and ticks) plus the irq line, mirroring and work RAM controls as
// they stand after the item. Writes and ticks pass from acceptance to the emit
// state and then load the result register; translations first go through the
// shared restoring remainder unit, which reduces the bank number modulo the
// bank count at one bit per cycle over eight steps, after operand capture at
// acceptance and before result selection and output load. The output load
// waits while an untaken result still holds the output register. The block
// takes one item at a time; a new item is accepted as soon as the sequencer
// is idle, even while the previous result is still waiting in the output
// register. Configuration writes are taken whenever cfg_write is high and
// must only happen while no item is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

`include "bank_switch_scanline_irq_mapper_defines.svh"

module bank_switch_scanline_irq_mapper import bsim_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst,
  bsim_item_if.sink                   items,
  bsim_result_if.source               results,
  input  wire logic                   cfg_write,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  // configuration
  logic [5:0] prg_banks_16k;
  logic [5:0] chr_banks_8k;
  logic       four_screen;

  // mapper state
  logic [7:0] bank_select;
  logic [7:0] bank_regs [BANK_REG_COUNT];
  logic [7:0] irq_latch;
  logic [7:0] irq_counter;
  logic       reload_flag;
  logic       irq_enable;
  logic       irq_line;
  logic [1:0] mirror_mode;
  logic       ram_on;
  logic       ram_write_ok;

  // sequencer
  state_t     state;
  state_t     state_next;
  bank_sel_t  sel;
  bank_sel_t  sel_next;
  logic [7:0] bank_res;
  logic [6:0] prg_count_q;

  div_req_t   div_req;
  div_resp_t  div_resp;

  // output register
  logic       out_valid;
  logic [7:0] out_bank;
  logic       out_irq;
  logic [1:0] out_mirroring;
  logic       out_ram_enable;
  logic       out_ram_writable;

  logic accept;
  logic load_out;

  assign items.ready = (state == ST_IDLE);
  assign accept      = items.valid && items.ready;
  assign load_out    = (state == ST_EMIT) && (!out_valid || results.ready);

  // ---------------------------------------------------------------------------
  // translation operand selection
  // ---------------------------------------------------------------------------
  logic [6:0]            prg_count;
  logic [8:0]            chr_count;
  logic [12:0]           chr_addr;
  logic [7:0]            chr_raw;
  logic [7:0]            prg_raw;
  logic                  prg_swap;

  assign prg_count = {prg_banks_16k, 1'b0};
  assign chr_count = {chr_banks_8k, 3'b000};
  assign prg_swap  = bank_select[SEL_PRG_SWAP_BIT];
  // bit 7 of bank select swaps the two pattern halves
  assign chr_addr  = items.address[12:0] ^ {bank_select[SEL_CHR_SWAP_BIT], 12'd0};

  always_comb begin
    case (chr_addr[12:10])
      3'd0:    chr_raw = bank_regs[0] & PAIR_MASK;
      3'd1:    chr_raw = bank_regs[0] | 8'd1;
      3'd2:    chr_raw = bank_regs[1] & PAIR_MASK;
      3'd3:    chr_raw = bank_regs[1] | 8'd1;
      default: chr_raw = bank_regs[BANK_IDX_W'(chr_addr[12:10] - 3'd2)];
    endcase
  end

  always_comb begin
    prg_raw  = bank_regs[6];
    sel_next = SEL_REM;
    if (items.func == FUNC_PRG) begin
      if (!items.address[15] || (prg_banks_16k == '0)) begin
        sel_next = SEL_ZERO;
      end else begin
        case (items.address[14:13])
          2'd0:    sel_next = prg_swap ? SEL_SECOND_LAST : SEL_REM;
          2'd1: begin
            sel_next = SEL_REM;
            prg_raw  = bank_regs[7];
          end
          2'd2:    sel_next = prg_swap ? SEL_REM : SEL_SECOND_LAST;
          default: sel_next = SEL_LAST;
        endcase
      end
    end else if (chr_banks_8k == '0) begin
      sel_next = SEL_ZERO;
    end
  end

  // both translations go through the remainder unit
  assign div_req.start    = accept && items.func[1];
  assign div_req.dividend = (items.func == FUNC_PRG) ? prg_raw : chr_raw;
  assign div_req.divisor  = (items.func == FUNC_PRG) ? {2'b00, prg_count} : chr_count;

  bsim_divider u_divider (
    .clk  (clk),
    .rst  (rst),
    .req  (div_req),
    .resp (div_resp)
  );

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = items.func[1] ? ST_DIV : ST_EMIT;
        end
      end
      ST_DIV: begin
        if (div_resp.done) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (load_out) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // translated bank pick once the remainder is ready
  always_ff @(posedge clk) begin
    if (accept) begin
      sel         <= sel_next;
      prg_count_q <= prg_count;
      bank_res    <= '0;
    end else if ((state == ST_DIV) && div_resp.done) begin
      case (sel)
        SEL_REM:         bank_res <= div_resp.remainder[7:0];
        SEL_SECOND_LAST: bank_res <= {1'b0, prg_count_q} - 8'd2;
        SEL_LAST:        bank_res <= {1'b0, prg_count_q} - 8'd1;
        default:         bank_res <= '0;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // register writes, scanline ticks and configuration
  // ---------------------------------------------------------------------------
  logic [15:0]           reg_addr;
  logic [BANK_IDX_W-1:0] data_idx;
  logic                  do_write;
  logic                  do_tick;
  logic [7:0]            counter_new;
  logic                  counter_reload;

  assign reg_addr       = items.address & REG_MASK;
  assign data_idx       = bank_select[BANK_IDX_W-1:0];
  assign do_write       = accept && (items.func == FUNC_WRITE);
  assign do_tick        = accept && (items.func == FUNC_TICK) && items.rendering_on;
  assign counter_reload = (irq_counter == '0) || reload_flag;
  assign counter_new    = counter_reload ? irq_latch : irq_counter - 8'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      prg_banks_16k <= 6'd32;
      chr_banks_8k  <= 6'd32;
      four_screen   <= 1'b0;
      bank_select   <= '0;
      for (int i = 0; i < BANK_REG_COUNT; i++) begin
        bank_regs[i] <= BANK_REG_INIT[i];
      end
      irq_latch     <= '0;
      irq_counter   <= '0;
      reload_flag   <= 1'b0;
      irq_enable    <= 1'b0;
      irq_line      <= 1'b0;
      mirror_mode   <= MIRROR_VERTICAL;
      ram_on        <= 1'b1;
      ram_write_ok  <= 1'b1;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_PRG_BANKS: prg_banks_16k <= cfg_data;
          CFG_CHR_BANKS: chr_banks_8k  <= cfg_data;
          CFG_FOUR_SCREEN: begin
            four_screen <= cfg_data[0];
            // four-screen overrides mirroring, and leaving it falls back to vertical
            if (cfg_data[0]) begin
              mirror_mode <= MIRROR_FOUR_SCREEN;
            end else if (mirror_mode == MIRROR_FOUR_SCREEN) begin
              mirror_mode <= MIRROR_VERTICAL;
            end
          end
          default: ;
        endcase
      end else if (do_write) begin
        case (reg_addr)
          REG_BANK_SELECT: bank_select <= items.value;
          REG_BANK_DATA: begin
            // the 2K pattern pairs keep an even base
            if (data_idx < BANK_IDX_W'(2)) begin
              bank_regs[data_idx] <= items.value & PAIR_MASK;
            end else begin
              bank_regs[data_idx] <= items.value;
            end
          end
          REG_MIRROR: begin
            if (!four_screen) begin
              mirror_mode <= {1'b0, items.value[0]};
            end
          end
          REG_RAM_PROTECT: begin
            ram_on       <= items.value[7];
            ram_write_ok <= ~items.value[6];
          end
          REG_IRQ_LATCH:  irq_latch   <= items.value;
          REG_IRQ_RELOAD: reload_flag <= 1'b1;
          REG_IRQ_DISABLE: begin
            irq_enable <= 1'b0;
            irq_line   <= 1'b0;
          end
          REG_IRQ_ENABLE: irq_enable <= 1'b1;
          default: ;
        endcase
      end else if (do_tick) begin
        irq_counter <= counter_new;
        if (counter_new == '0) begin
          // counter hit zero: arm a reload and fire if enabled
          reload_flag <= 1'b1;
          if (irq_enable) begin
            irq_line <= 1'b1;
          end
        end else if (counter_reload) begin
          reload_flag <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_bank         <= bank_res;
      out_irq          <= irq_line;
      out_mirroring    <= mirror_mode;
      out_ram_enable   <= ram_on;
      out_ram_writable <= ram_write_ok;
    end
  end

  assign results.valid        = out_valid;
  assign results.bank         = out_bank;
  assign results.irq          = out_irq;
  assign results.mirroring    = out_mirroring;
  assign results.ram_enable   = out_ram_enable;
  assign results.ram_writable = out_ram_writable;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  // a translation always hands off to the remainder unit
  `BSIM_ASSERT_NEXT(a_translate_enters_div, accept && items.func[1], state == ST_DIV)
  // the remainder unit only finishes while the sequencer waits for it
  `BSIM_ASSERT_NOW(a_done_only_in_div, div_resp.done, state == ST_DIV)
  // the irq line only rises on a counted scanline tick
  `BSIM_ASSERT_NOW(a_irq_rise_on_tick, $rose(irq_line), $past(do_tick))

endmodule

`default_nettype wire
